// ===== rtl/rrlc_pkg.sv =====
// Shared types and constants for the rounded rectangle coverage block.
// Used by the front pipeline, the root cells and the top level.
`timescale 1ns / 1ps
package rrlc_pkg;

   // square root operand width and one cell per result bit
   localparam int ROOT_W     = 42;
   localparam int ROOT_CELLS = 21;
   localparam int RES_W      = 22;

   localparam logic [5:0] COV_FULL = 6'd32;

   // register indexes on the configuration channel
   localparam logic [2:0] CSR_CENTER    = 3'd0;
   localparam logic [2:0] CSR_ROTATION  = 3'd1;
   localparam logic [2:0] CSR_HALF_SIZE = 3'd2;
   localparam logic [2:0] CSR_RADII     = 3'd3;
   localparam logic [2:0] CSR_UPPER_LID = 3'd4;
   localparam logic [2:0] CSR_LOWER_LID = 3'd5;

   typedef struct packed {
      logic [31:0] center;
      logic [31:0] rotation;
      logic [31:0] half_size;
      logic [47:0] corner_radii;
      logic [55:0] upper_lid;
      logic [55:0] lower_lid;
   } cfg_type;

   // running state of the restoring square root
   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] res;
   } root_state_type;

   // data carried alongside the root through the cell chain
   typedef struct packed {
      logic signed [21:0] alt;
      logic               use_root;
      logic [11:0]        radius;
      logic [5:0]         upper_cov;
      logic [5:0]         lower_cov;
   } side_type;

endpackage

// ===== rtl/rrlc_root_cell.sv =====
// One step of the restoring integer square root, registered.
// Depends on rrlc_pkg for the root state type.
`timescale 1ns / 1ps
module rrlc_root_cell #(
   parameter int BIT_POS = 0,
   parameter int SIDE_W  = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  rrlc_pkg::root_state_type in_root,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output rrlc_pkg::root_state_type out_root,
   output logic [SIDE_W-1:0]       out_side
);

   localparam logic [rrlc_pkg::ROOT_W-1:0] STEP_BIT = rrlc_pkg::ROOT_W'(1) << BIT_POS;

   logic                     valid_ff;
   rrlc_pkg::root_state_type root_ff, root_in;
   logic [SIDE_W-1:0]        side_ff;
   logic [rrlc_pkg::ROOT_W-1:0] trial;

   // try to subtract the trial value, shift the result
   always_comb begin
      trial = in_root.res + STEP_BIT;
      if (in_root.rem >= trial) begin
         root_in.rem = in_root.rem - trial;
         root_in.res = (in_root.res >> 1) + STEP_BIT;
      end else begin
         root_in.rem = in_root.rem;
         root_in.res = in_root.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/rrlc_front.sv =====
// Front pipeline: translate, rotate, box geometry, squares and lid cuts.
// Depends on rrlc_pkg; feeds the square root cell chain.
`timescale 1ns / 1ps
module rrlc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  rrlc_pkg::cfg_type        cfg,
   input  logic                     in_valid,
   input  logic signed [15:0]       point_x,
   input  logic signed [15:0]       point_y,
   output logic                     out_valid,
   output rrlc_pkg::root_state_type out_root,
   output rrlc_pkg::side_type       out_side
);

   logic [5:0] valid_ff;

   // stage 1
   logic signed [16:0] dx_ff, dy_ff;
   // stage 2
   logic signed [32:0] cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   // stage 3
   logic signed [19:0] lx3_ff, ly3_ff;
   logic signed [33:0] sum_x, sum_y;
   // stage 4
   logic signed [20:0] qx_ff, qy_ff;
   logic [11:0]        r4_ff;
   logic signed [19:0] ly4_ff;
   logic signed [39:0] spu4_ff, spl4_ff;
   logic [38:0]        lx2_ff;
   logic [11:0]        r_sel;
   logic [19:0]        ax, ay;
   logic signed [17:0] hw_r, hh_r;
   logic signed [39:0] lx_sq;
   // stage 5
   logic signed [21:0] alt_ff;
   logic               use_root_ff;
   logic [11:0]        r5_ff;
   logic signed [19:0] ly5_ff;
   logic signed [39:0] spu5_ff, spl5_ff;
   logic [39:0]        sqx_ff, sqy_ff;
   logic signed [40:0] plo_u_ff, plo_l_ff;
   logic signed [39:0] phi_u_ff, phi_l_ff;
   logic signed [20:0] q_max;
   logic [19:0]        px, py;
   // stage 6
   rrlc_pkg::root_state_type root_ff;
   rrlc_pkg::side_type       side_ff;
   logic signed [41:0] line_u, line_l, d_u, d_l;
   logic [5:0]         cov_u, cov_l;

   function automatic logic [5:0] lid_ramp(input logic signed [41:0] d);
      logic signed [43:0] t;
      begin
         t = {d[41], d, 1'b0} + 44'sd16;
         if (t < 0) begin
            lid_ramp = 6'd0;
         end else if (t > 44'sd32) begin
            lid_ramp = rrlc_pkg::COV_FULL;
         end else begin
            lid_ramp = t[5:0];
         end
      end
   endfunction

   // hold valid bits for every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // stage 3 sums and stage 4 geometry
   always_comb begin
      sum_x = {cdx_ff[32], cdx_ff} + {sdy_ff[32], sdy_ff};
      sum_y = {cdy_ff[32], cdy_ff} - {sdx_ff[32], sdx_ff};
      case ({~ly3_ff[19], ~lx3_ff[19]})
         2'd0:    r_sel = cfg.corner_radii[11:0];
         2'd1:    r_sel = cfg.corner_radii[23:12];
         2'd2:    r_sel = cfg.corner_radii[35:24];
         default: r_sel = cfg.corner_radii[47:36];
      endcase
      ax    = lx3_ff[19] ? 20'(-lx3_ff) : lx3_ff;
      ay    = ly3_ff[19] ? 20'(-ly3_ff) : ly3_ff;
      hw_r  = $signed({2'b00, cfg.half_size[15:0]}) - $signed({6'd0, r_sel});
      hh_r  = $signed({2'b00, cfg.half_size[31:16]}) - $signed({6'd0, r_sel});
      lx_sq = lx3_ff * lx3_ff;
   end

   // stage 5 selection
   always_comb begin
      q_max = (qx_ff > qy_ff) ? qx_ff : qy_ff;
      px    = (qx_ff > 0) ? qx_ff[19:0] : 20'd0;
      py    = (qy_ff > 0) ? qy_ff[19:0] : 20'd0;
   end

   // stage 6 lid lines
   always_comb begin
      line_u = 42'(cfg.upper_lid[15:0] & 16'hFFFF) - 42'd0;
      line_u = {{26{cfg.upper_lid[15]}}, cfg.upper_lid[15:0]}
             + {{14{spu5_ff[39]}}, spu5_ff[39:12]}
             + {{2{phi_u_ff[39]}}, phi_u_ff}
             + {{21{plo_u_ff[40]}}, plo_u_ff[40:20]};
      line_l = {{26{cfg.lower_lid[15]}}, cfg.lower_lid[15:0]}
             + {{14{spl5_ff[39]}}, spl5_ff[39:12]}
             + {{2{phi_l_ff[39]}}, phi_l_ff}
             + {{21{plo_l_ff[40]}}, plo_l_ff[40:20]};
      d_u   = {{22{ly5_ff[19]}}, ly5_ff} - line_u;
      d_l   = line_l - {{22{ly5_ff[19]}}, ly5_ff};
      cov_u = lid_ramp(d_u);
      cov_l = lid_ramp(d_l);
   end

   // advance the datapath
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= {point_x[15], point_x} - {cfg.center[15], cfg.center[15:0]};
         dy_ff <= {point_y[15], point_y} - {cfg.center[31], cfg.center[31:16]};

         cdx_ff <= $signed(cfg.rotation[15:0]) * dx_ff;
         sdy_ff <= $signed(cfg.rotation[31:16]) * dy_ff;
         cdy_ff <= $signed(cfg.rotation[15:0]) * dy_ff;
         sdx_ff <= $signed(cfg.rotation[31:16]) * dx_ff;

         lx3_ff <= sum_x[33:14];
         ly3_ff <= sum_y[33:14];

         qx_ff   <= $signed({1'b0, ax}) - {{3{hw_r[17]}}, hw_r};
         qy_ff   <= $signed({1'b0, ay}) - {{3{hh_r[17]}}, hh_r};
         r4_ff   <= r_sel;
         ly4_ff  <= ly3_ff;
         spu4_ff <= $signed(cfg.upper_lid[35:16]) * lx3_ff;
         spl4_ff <= $signed(cfg.lower_lid[35:16]) * lx3_ff;
         lx2_ff  <= lx_sq[38:0];

         alt_ff      <= {q_max[20], q_max} - $signed({10'd0, r4_ff});
         use_root_ff <= (qx_ff > 0) && (qy_ff > 0);
         r5_ff       <= r4_ff;
         ly5_ff      <= ly4_ff;
         spu5_ff     <= spu4_ff;
         spl5_ff     <= spl4_ff;
         sqx_ff      <= px * px;
         sqy_ff      <= py * py;
         plo_u_ff    <= $signed(cfg.upper_lid[55:36]) * $signed({1'b0, lx2_ff[19:0]});
         phi_u_ff    <= $signed(cfg.upper_lid[55:36]) * $signed({1'b0, lx2_ff[38:20]});
         plo_l_ff    <= $signed(cfg.lower_lid[55:36]) * $signed({1'b0, lx2_ff[19:0]});
         phi_l_ff    <= $signed(cfg.lower_lid[55:36]) * $signed({1'b0, lx2_ff[38:20]});

         root_ff.rem        <= {2'b00, sqx_ff} + {2'b00, sqy_ff};
         root_ff.res        <= '0;
         side_ff.alt        <= alt_ff;
         side_ff.use_root   <= use_root_ff;
         side_ff.radius     <= r5_ff;
         side_ff.upper_cov  <= cov_u;
         side_ff.lower_cov  <= cov_l;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/rounded_rect_lid_coverage.sv =====
// Top level of the rounded rectangle coverage block with lid cuts.
// Depends on rrlc_pkg, rrlc_front and rrlc_root_cell.
`timescale 1ns / 1ps
// Usage:
//   req_ channel carries one sample point per transfer (x low, y high, Q4).
//   rsp_ channel returns one coverage value (0..32) per point, in order.
//   csr_ channel writes one register per transfer; it is always ready.
//   Write configuration only while no point is in flight.
// Pipeline: an accepted point passes through six front stages, a chain of
//   21 square root cells (one result bit each) and the output register.
// Throughput: one point per cycle while the output is not stalled; every
//   stage is a register and the square root advances one cell per cycle.
// Stall: when the output register holds a result that is not taken, the
//   whole pipeline freezes and req_tready drops in the same cycle.
// Reset: clears all valid bits and returns the registers to their reset
//   values (rotation to cosine 1.0, all others to zero).
module rounded_rect_lid_coverage (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] coverage, [7:6] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [55:0] csr_data
);

   localparam int SIDE_W = $bits(rrlc_pkg::side_type);
   localparam int N      = rrlc_pkg::ROOT_CELLS;

   rrlc_pkg::cfg_type cfg_ff;
   logic              en;

   logic                     chain_valid [N+1];
   rrlc_pkg::root_state_type chain_root  [N+1];
   logic [SIDE_W-1:0]        chain_side  [N+1];
   rrlc_pkg::side_type       front_side, last_side;

   logic                 rsp_valid_ff;
   logic [5:0]           cov_ff, cov_in;
   logic signed [23:0]   shape_dist;
   logic signed [25:0]   ramp_t;
   logic [5:0]           box_cov;

   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center       <= '0;
         cfg_ff.rotation     <= 32'd16384;
         cfg_ff.half_size    <= '0;
         cfg_ff.corner_radii <= '0;
         cfg_ff.upper_lid    <= '0;
         cfg_ff.lower_lid    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            rrlc_pkg::CSR_CENTER:    cfg_ff.center       <= csr_data[31:0];
            rrlc_pkg::CSR_ROTATION:  cfg_ff.rotation     <= csr_data[31:0];
            rrlc_pkg::CSR_HALF_SIZE: cfg_ff.half_size    <= csr_data[31:0];
            rrlc_pkg::CSR_RADII:     cfg_ff.corner_radii <= csr_data[47:0];
            rrlc_pkg::CSR_UPPER_LID: cfg_ff.upper_lid    <= csr_data;
            rrlc_pkg::CSR_LOWER_LID: cfg_ff.lower_lid    <= csr_data;
            default: ;
         endcase
      end
   end

   rrlc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .point_x   ($signed(req_tdata[15:0])),
      .point_y   ($signed(req_tdata[31:16])),
      .out_valid (chain_valid[0]),
      .out_root  (chain_root[0]),
      .out_side  (front_side)
   );

   assign chain_side[0] = front_side;

   // square root chain, most significant bit pair first
   for (genvar k = 0; k < N; k++) begin : g_cell
      rrlc_root_cell #(
         .BIT_POS (2 * (N - 1 - k)),
         .SIDE_W  (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[k]),
         .in_root   (chain_root[k]),
         .in_side   (chain_side[k]),
         .out_valid (chain_valid[k+1]),
         .out_root  (chain_root[k+1]),
         .out_side  (chain_side[k+1])
      );
   end

   // distance, ramp and lid caps
   always_comb begin
      last_side = chain_side[N];
      if (last_side.use_root) begin
         shape_dist = $signed({2'b00, chain_root[N].res[rrlc_pkg::RES_W-1:0]})
                    - $signed({12'd0, last_side.radius});
      end else begin
         shape_dist = {{2{last_side.alt[21]}}, last_side.alt};
      end
      ramp_t = (26'sd8 - {{2{shape_dist[23]}}, shape_dist}) <<< 1;
      if (ramp_t < 0) begin
         box_cov = 6'd0;
      end else if (ramp_t > 26'sd32) begin
         box_cov = rrlc_pkg::COV_FULL;
      end else begin
         box_cov = ramp_t[5:0];
      end
      cov_in = box_cov;
      if (box_cov != 6'd0) begin
         if (last_side.upper_cov < cov_in) begin
            cov_in = last_side.upper_cov;
         end
         if (last_side.lower_cov < cov_in) begin
            cov_in = last_side.lower_cov;
         end
      end
   end

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain_valid[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cov_ff <= cov_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, cov_ff};

endmodule

// ===== verif/rounded_rect_lid_coverage_tb.sv =====
// Self-checking testbench for the rounded rectangle coverage block.
// Depends on rrlc_pkg and rounded_rect_lid_coverage; a scoreboard class
// predicts each coverage value and tasks drive the stream and register ports.
`timescale 1ns / 1ps

// Holds a copy of the registers, predicts coverage, keeps results in order
class coverage_scoreboard;
   logic [31:0] center;
   logic [31:0] rotation;
   logic [31:0] half_size;
   logic [47:0] corner_radii;
   logic [55:0] upper_lid;
   logic [55:0] lower_lid;
   logic [5:0]  pending_cov[$];
   int          errors;

   function void reset_regs();
      center       = '0;
      rotation     = 32'd16384;
      half_size    = '0;
      corner_radii = '0;
      upper_lid    = '0;
      lower_lid    = '0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [55:0] value);
      case (idx)
         rrlc_pkg::CSR_CENTER:    center       = value[31:0];
         rrlc_pkg::CSR_ROTATION:  rotation     = value[31:0];
         rrlc_pkg::CSR_HALF_SIZE: half_size    = value[31:0];
         rrlc_pkg::CSR_RADII:     corner_radii = value[47:0];
         rrlc_pkg::CSR_UPPER_LID: upper_lid    = value;
         rrlc_pkg::CSR_LOWER_LID: lower_lid    = value;
         default: ;
      endcase
   endfunction

   // floor square root, one result bit per pass
   function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned acc;
      longint unsigned bitv;
      acc  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= acc + bitv) begin
            n   = n - (acc + bitv);
            acc = (acc >> 1) + bitv;
         end else begin
            acc = acc >> 1;
         end
         bitv = bitv >> 2;
      end
      return acc;
   endfunction

   function longint clamp_cov(longint v);
      if (v < 0) return 0;
      if (v > 32) return 32;
      return v;
   endfunction

   // signed distance to the rounded box in the local frame
   function longint box_dist(longint lx, longint ly);
      int     corner;
      longint r, hw, hh, ax, ay, qx, qy, px, py;
      corner = (ly < 0 ? 0 : 2) + (lx < 0 ? 0 : 1);
      r  = longint'((corner_radii >> (12 * corner)) & 48'hFFF);
      hw = longint'(half_size[15:0]);
      hh = longint'(half_size[31:16]);
      ax = lx < 0 ? -lx : lx;
      ay = ly < 0 ? -ly : ly;
      qx = ax - (hw - r);
      qy = ay - (hh - r);
      if (qx <= 0 && qy <= 0) return (qx > qy ? qx : qy) - r;
      px = qx > 0 ? qx : 0;
      py = qy > 0 ? qy : 0;
      if (px == 0) return py - r;
      if (py == 0) return px - r;
      return longint'(int_sqrt(px * px + py * py)) - r;
   endfunction

   function longint lid_cov(logic [55:0] lid, longint lx, longint ly, bit top);
      longint base, slope, bend, edge_y, d;
      base   = longint'($signed(lid[15:0]));
      slope  = longint'($signed(lid[35:16]));
      bend   = longint'($signed(lid[55:36]));
      edge_y = base + ((slope * lx) >>> 12) + ((bend * lx * lx) >>> 20);
      d = ly - edge_y;
      if (!top) d = -d;
      return clamp_cov(d * 2 + 16);
   endfunction

   function logic [5:0] predict_cov(logic [15:0] px, logic [15:0] py);
      longint dx, dy, c, s, lx, ly, a, u, l;
      dx = longint'($signed(px)) - longint'($signed(center[15:0]));
      dy = longint'($signed(py)) - longint'($signed(center[31:16]));
      c  = longint'($signed(rotation[15:0]));
      s  = longint'($signed(rotation[31:16]));
      lx = (c * dx + s * dy) >>> 14;
      ly = (c * dy - s * dx) >>> 14;
      a  = clamp_cov((8 - box_dist(lx, ly)) * 2);
      if (a != 0) begin
         u = lid_cov(upper_lid, lx, ly, 1'b1);
         l = lid_cov(lower_lid, lx, ly, 1'b0);
         if (u < a) a = u;
         if (l < a) a = l;
      end
      return a[5:0];
   endfunction

   function void note_point(logic [15:0] px, logic [15:0] py);
      pending_cov.push_back(predict_cov(px, py));
   endfunction

   function void check_coverage(logic [5:0] got);
      logic [5:0] want;
      if (pending_cov.size() == 0) begin
         $error("coverage: unexpected transfer, actual %0d", got);
         errors++;
         return;
      end
      want = pending_cov.pop_front();
      if (got !== want) begin
         $error("coverage: expected %0d, actual %0d", want, got);
         errors++;
      end
   endfunction
endclass

module rounded_rect_lid_coverage_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [55:0] csr_data = '0;

   coverage_scoreboard sb;
   int cycles = 0;
   int stall_left = 0;
   bit stall_quiet = 1'b0;

   rounded_rect_lid_coverage uut (.*);

   always #2 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rounded_rect_lid_coverage_tb NOT OK");
         $finish;
      end
   end

   // check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_coverage(rsp_tdata[5:0]);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver back-pressure: short stalls mostly, some long, quiet stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
         if ($urandom_range(0, 199) == 0) stall_quiet = ~stall_quiet;
         if (!stall_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   task automatic send_point(logic [15:0] px, logic [15:0] py);
      int gap;
      req_tdata  = {py, px};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_point(px, py);
      @(negedge clock);
      gap = stall_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold off until every result is back, then let the pipeline empty
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending_cov.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [55:0] value);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [15:0] rand_signed(int span);
      return 16'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // realistic settings: rotated box, moderate radii, lids near the edges
   task automatic write_shape(bit unit_rot);
      real         ang;
      logic [15:0] hw, hh, cs, sn;
      logic [19:0] slope, bend;
      ang = $urandom_range(0, 6283) / 1000.0;
      cs  = unit_rot ? 16'($rtoi(16384.0 * $cos(ang))) : 16'($urandom);
      sn  = unit_rot ? 16'($rtoi(16384.0 * $sin(ang))) : 16'($urandom);
      hw  = 16'($urandom_range(16, 1600));
      hh  = 16'($urandom_range(16, 1600));
      write_csr(rrlc_pkg::CSR_CENTER, {24'd0, rand_signed(8000), rand_signed(8000)});
      write_csr(rrlc_pkg::CSR_ROTATION, {24'd0, sn, cs});
      write_csr(rrlc_pkg::CSR_HALF_SIZE, {24'd0, hh, hw});
      write_csr(rrlc_pkg::CSR_RADII,
                {8'd0, 12'($urandom_range(0, 1200)), 12'($urandom_range(0, 1200)),
                 12'($urandom_range(0, 1200)), 12'($urandom_range(0, 4095))});
      slope = 20'($signed($urandom_range(0, 8192)) - 4096);
      bend  = 20'($signed($urandom_range(0, 256)) - 128);
      write_csr(rrlc_pkg::CSR_UPPER_LID,
                {bend, slope, 16'(-$signed({1'b0, hh}) + rand_signed(300))});
      slope = 20'($signed($urandom_range(0, 8192)) - 4096);
      bend  = 20'($signed($urandom_range(0, 256)) - 128);
      write_csr(rrlc_pkg::CSR_LOWER_LID,
                {bend, slope, 16'($signed({1'b0, hh}) + rand_signed(300))});
   endtask

   task automatic write_all(logic [55:0] value);
      write_csr(rrlc_pkg::CSR_CENTER, value);
      write_csr(rrlc_pkg::CSR_ROTATION, value);
      write_csr(rrlc_pkg::CSR_HALF_SIZE, value);
      write_csr(rrlc_pkg::CSR_RADII, value);
      write_csr(rrlc_pkg::CSR_UPPER_LID, value);
      write_csr(rrlc_pkg::CSR_LOWER_LID, value);
   endtask

   // points mostly within the larger half size plus a margin of the center, some raw noise
   task automatic random_points(int count);
      int          span;
      logic [15:0] px, py;
      span = int'(sb.half_size[15:0] > sb.half_size[31:16] ?
                  sb.half_size[15:0] : sb.half_size[31:16]) + 96;
      if (span > 32000) span = 32000;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            px = 16'($urandom);
            py = 16'($urandom);
         end else begin
            px = sb.center[15:0] + rand_signed(span);
            py = sb.center[31:16] + rand_signed(span);
         end
         send_point(px, py);
      end
   endtask

   initial begin
      sb = new();
      sb.reset_regs();
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // reset settings: extremes of both fields and the axes
      send_point(16'h8000, 16'h8000);
      send_point(16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h7FFF);
      send_point(16'h7FFF, 16'h8000);
      send_point(16'h0000, 16'h0000);
      send_point(16'h0004, 16'h0000);
      send_point(16'hFFFC, 16'h0000);
      send_point(16'h0000, 16'h0004);
      send_point(16'h0000, 16'hFFFC);
      send_point(16'hFFFF, 16'hFFFF);
      drain();

      // axis-aligned box with one radius per corner, lids fully open
      write_csr(rrlc_pkg::CSR_HALF_SIZE, {24'd0, 16'd160, 16'd320});
      write_csr(rrlc_pkg::CSR_RADII, {8'd0, 12'd96, 12'd64, 12'd32, 12'd0});
      write_csr(rrlc_pkg::CSR_UPPER_LID, {20'd0, 20'd0, 16'h8000});
      write_csr(rrlc_pkg::CSR_LOWER_LID, {20'd0, 20'd0, 16'h7FFF});
      // corner choice at exactly zero and corner regions
      send_point(16'd0, 16'd0);
      send_point(16'd320, 16'd0);
      send_point(-16'sd320, 16'd0);
      send_point(16'd0, 16'd160);
      send_point(16'd0, -16'sd160);
      send_point(16'd318, 16'd158);
      send_point(-16'sd318, -16'sd158);
      send_point(-16'sd316, 16'd156);
      send_point(16'd316, -16'sd156);
      drain();
      // radius beyond half size makes the straight part negative
      write_csr(rrlc_pkg::CSR_RADII, {8'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
      send_point(16'd100, 16'd50);
      send_point(-16'sd400, 16'd300);
      drain();

      // out-of-range indexes leave the registers untouched
      write_csr(3'd6, 56'hFF_FFFF_FFFF_FFFF);
      write_csr(3'd7, 56'h55_AAAA_5555_AAAA);
      random_points(20);
      drain();

      // extremes: all ones, then all zeros
      write_all(56'hFF_FFFF_FFFF_FFFF);
      random_points(30);
      drain();
      write_all(56'd0);
      random_points(30);
      drain();

      // realistic shapes, one with a rotation that is not a unit vector
      for (int phase = 0; phase < 7; phase++) begin
         write_shape(phase != 3);
         random_points(30);
         drain();
         random_points(30);
         drain();
      end

      while (sb.pending_cov.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (sb.errors == 0) begin
         $display("rounded_rect_lid_coverage_tb OK");
      end else begin
         $display("rounded_rect_lid_coverage_tb NOT OK");
      end
      $finish;
   end
endmodule
